FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/pli_pkg.sv
package pli_pkg;

	localparam int unsigned MAX_POINTS_DEF  = 32;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	// sequencer step addresses
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_TEST,
		ST_SEL,
		ST_DBL,
		ST_ADD,
		ST_FIN,
		ST_OUT
	} step_t;

	// datapath operation of one step
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_READ,
		OP_TEST,
		OP_SEL,
		OP_DBL,
		OP_ADD,
		OP_FIN,
		OP_OUT
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_QUERY,
		C_MORE,
		C_DIRECT,
		C_BITS,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jump;
		step_t next;
	} ctrl_t;

	// control store: jump when cond holds, else fall to next
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		unique case (s)
			ST_IDLE: w = '{op: OP_IDLE, cond: C_QUERY,    jump: ST_READ, next: ST_IDLE};
			ST_READ: w = '{op: OP_READ, cond: C_NEVER,    jump: ST_READ, next: ST_TEST};
			ST_TEST: w = '{op: OP_TEST, cond: C_MORE,     jump: ST_READ, next: ST_SEL};
			ST_SEL:  w = '{op: OP_SEL,  cond: C_DIRECT,   jump: ST_OUT,  next: ST_DBL};
			ST_DBL:  w = '{op: OP_DBL,  cond: C_NEVER,    jump: ST_DBL,  next: ST_ADD};
			ST_ADD:  w = '{op: OP_ADD,  cond: C_BITS,     jump: ST_DBL,  next: ST_FIN};
			ST_FIN:  w = '{op: OP_FIN,  cond: C_NEVER,    jump: ST_FIN,  next: ST_OUT};
			ST_OUT:  w = '{op: OP_OUT,  cond: C_OUT_BUSY, jump: ST_OUT,  next: ST_IDLE};
			default: w = '{op: OP_IDLE, cond: C_NEVER,    jump: ST_IDLE, next: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: hdl/pli_table.sv
// Breakpoint store: one write port, one read port, registered read data.
module pli_table #(
	parameter int unsigned MAX_POINTS  = pli_pkg::MAX_POINTS_DEF,
	parameter int unsigned VALUE_WIDTH = pli_pkg::VALUE_WIDTH_DEF,
	localparam int unsigned AW = $clog2(MAX_POINTS)
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [VALUE_WIDTH-1:0] wx,
	input  logic [VALUE_WIDTH-1:0] wy,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output logic [VALUE_WIDTH-1:0] rx,
	output logic [VALUE_WIDTH-1:0] ry
);

	logic [VALUE_WIDTH-1:0] mem_x [MAX_POINTS];
	logic [VALUE_WIDTH-1:0] mem_y [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[waddr] <= wx;
			mem_y[waddr] <= wy;
		end
		if (re) begin
			rx <= mem_x[raddr];
			ry <= mem_y[raddr];
		end
	end

endmodule

FILE: hdl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator, signed Q16.16 breakpoint table.
// Input channel (in_valid/in_ready): a beat with action = 0 loads one
// breakpoint (x_value, y_value) into slot point_index and gives no result;
// action = 1 is a query on x_value. Output channel (out_valid/out_ready):
// one beat per query with y_out, out_of_range and last_result.
// The user must write num_points through cfg_we only while the block is
// idle; the block itself does not enforce this. A load is written into
// the table as it is accepted. A query runs a search over the breakpoints,
// each a registered table read then a compare, then picks the case, then
// either posts an end or exact value, or runs a bit-serial scaled division
// (a doubling step and an add step per quotient bit) and a final step
// before it posts the result.
// in_ready is high only while the sequencer sits in its idle step, which it
// reaches again as soon as a result is posted to the output register, so the
// next beat is taken while that result waits. If the receiver stalls with a
// result still held, the following query waits at its output step.
// Reset: sequencer idle, output empty, num_points = 2; the table is
// undefined until loaded.
`include "assert_macros.svh"

module piecewise_linear_interpolator #(
	parameter int unsigned MAX_POINTS  = pli_pkg::MAX_POINTS_DEF,
	parameter int unsigned VALUE_WIDTH = pli_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [5:0]         num_points,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [4:0]         point_index,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	input  logic               last_query,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] y_out,
	output logic               out_of_range,
	output logic               last_result
);

	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned VW = VALUE_WIDTH;
	localparam int unsigned CW = $clog2(VW);
	// xor with the sign bit turns a signed order into an unsigned one
	localparam logic [VW-1:0] SIGN = VW'(1) << (VW - 1);

	pli_pkg::step_t upc_q, upc_nxt;
	pli_pkg::ctrl_t cw;
	logic           take;

	// datapath registers
	logic [AW-1:0] i_q;
	logic [AW-1:0] nm1_q;          // num_points - 1, clamped
	logic [VW-1:0] qx_q;           // query x
	logic          last_q;
	logic [VW-1:0] prev_x_q, prev_y_q;
	logic          end_q;          // search ran off the top of the table
	logic [VW-1:0] den_q, num_q, mul_q, r_q, quo_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] res_q;
	logic          flag_q;
	logic          out_valid_q;
	logic [31:0]   out_y_q;
	logic          out_flag_q, out_last_q;

	// table
	logic [VW-1:0] rd_x, rd_y;
	logic          tbl_we;

	// status
	logic          acc, lt, is_last, exact, direct, busy;
	logic [VW:0]   r2, s_add;
	logic          c1, c2;
	logic [VW-1:0] kx0, kx1, ky0, ky1, kq;

	assign in_ready = (upc_q == pli_pkg::ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign tbl_we   = acc && !action && (int'(point_index) < MAX_POINTS);

	pli_table #(
		.MAX_POINTS  (MAX_POINTS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(point_index)),
		.wx    (VW'(x_value)),
		.wy    (VW'(y_value)),
		.re    (cw.op == pli_pkg::OP_READ),
		.raddr (i_q),
		.rx    (rd_x),
		.ry    (rd_y)
	);

	assign kq  = qx_q ^ SIGN;
	assign kx0 = prev_x_q ^ SIGN;
	assign kx1 = rd_x ^ SIGN;
	assign ky0 = prev_y_q ^ SIGN;
	assign ky1 = rd_y ^ SIGN;

	assign lt      = kx1 < kq;
	assign is_last = (i_q == nm1_q);
	assign exact   = (rd_x == qx_q);
	assign direct  = end_q || exact || (i_q == '0);
	assign busy    = out_valid_q && !out_ready;

	// divider step: double the remainder, then add the scaled numerator
	assign r2    = {r_q, 1'b0};
	assign c1    = (r2 >= {1'b0, den_q});
	assign s_add = {1'b0, r_q} + {1'b0, num_q};
	assign c2    = mul_q[VW-1] && (s_add >= {1'b0, den_q});

	// sequencer
	assign cw = pli_pkg::ucode(upc_q);

	always_comb begin
		unique case (cw.cond)
			pli_pkg::C_NEVER:    take = 1'b0;
			pli_pkg::C_QUERY:    take = acc && action;
			pli_pkg::C_MORE:     take = lt && !is_last;
			pli_pkg::C_DIRECT:   take = direct;
			pli_pkg::C_BITS:     take = (cnt_q != '0);
			pli_pkg::C_OUT_BUSY: take = busy;
			default:             take = 1'b0;
		endcase
		upc_nxt = take ? cw.jump : cw.next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= pli_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			nm1_q       <= AW'(1);
		end else begin
			upc_q <= upc_nxt;
			if (cw.op == pli_pkg::OP_OUT && !busy) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (num_points < 6'd2) begin
					nm1_q <= AW'(1);
				end else if (int'(num_points) > MAX_POINTS) begin
					nm1_q <= AW'(MAX_POINTS - 1);
				end else begin
					nm1_q <= AW'(num_points - 6'd1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (cw.op)
			pli_pkg::OP_IDLE: begin
				if (acc && action) begin
					qx_q   <= VW'(x_value);
					last_q <= last_query;
					i_q    <= '0;
				end
			end
			pli_pkg::OP_READ: begin
				// read issued by the table port
			end
			pli_pkg::OP_TEST: begin
				end_q <= lt;
				if (lt) begin
					prev_x_q <= rd_x;
					prev_y_q <= rd_y;
					if (!is_last) begin
						i_q <= i_q + AW'(1);
					end
				end
			end
			pli_pkg::OP_SEL: begin
				res_q  <= rd_y;
				flag_q <= end_q || (!exact && (i_q == '0));
				den_q  <= kx1 - kx0;
				num_q  <= kq - kx0;
				neg_q  <= (ky1 < ky0);
				mul_q  <= (ky1 < ky0) ? (ky0 - ky1) : (ky1 - ky0);
				r_q    <= '0;
				quo_q  <= '0;
				cnt_q  <= CW'(VW - 1);
			end
			pli_pkg::OP_DBL: begin
				r_q   <= c1 ? VW'(r2 - {1'b0, den_q}) : VW'(r2);
				quo_q <= {quo_q[VW-2:0], c1};
			end
			pli_pkg::OP_ADD: begin
				if (mul_q[VW-1]) begin
					r_q <= c2 ? VW'(s_add - {1'b0, den_q}) : VW'(s_add);
				end
				quo_q <= quo_q + VW'(c2);
				mul_q <= {mul_q[VW-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
			pli_pkg::OP_FIN: begin
				res_q  <= neg_q ? (prev_y_q - quo_q) : (prev_y_q + quo_q);
				flag_q <= 1'b0;
			end
			pli_pkg::OP_OUT: begin
				if (!busy) begin
					out_y_q    <= 32'(res_q);
					out_flag_q <= flag_q;
					out_last_q <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign y_out        = out_y_q;
	assign out_of_range = out_flag_q;
	assign last_result  = out_last_q;

	// checks
	`ASSERT_CLKD(a_out_from_out_step, clk, arst_n,
		$rose(out_valid) |-> $past(upc_q == pli_pkg::ST_OUT),
		"result posted outside the output step")
	`ASSERT_CLKD(a_rem_below_den, clk, arst_n,
		(upc_q == pli_pkg::ST_ADD || upc_q == pli_pkg::ST_FIN) |-> (r_q < den_q),
		"divider remainder not below divisor")
	`ASSERT_CLKD(a_read_in_table, clk, arst_n,
		(upc_q == pli_pkg::ST_READ) |-> (i_q <= nm1_q),
		"table read beyond breakpoints in use")

endmodule

FILE: tb/piecewise_linear_interpolator_tb.sv
`timescale 1ns / 1ps

module piecewise_linear_interpolator_tb;

	localparam int TABLE_DEPTH = pli_pkg::MAX_POINTS_DEF;

	// beat kinds on the input channel
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Q16.16 extremes, held wide so ranges can be worked out without wrap
	localparam longint X_MIN  = -64'sd2147483648;
	localparam longint X_MAX  = 64'sd2147483647;
	localparam longint X_SPAN = 64'sd4294967295;

	// one beat as offered on the input channel
	typedef struct packed {
		logic               act;
		logic [4:0]         slot;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               last;
	} table_beat_t;

	// one result beat as it should come out
	typedef struct packed {
		logic signed [31:0] y;
		logic               off;
		logic               last;
	} lookup_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [5:0]         num_points = 6'd2;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = ACT_LOAD;
	logic [4:0]         point_index = '0;
	logic signed [31:0] x_value = '0;
	logic signed [31:0] y_value = '0;
	logic               last_query = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] y_out;
	logic               out_of_range;
	logic               last_result;

	piecewise_linear_interpolator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.num_points   (num_points),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.point_index  (point_index),
		.x_value      (x_value),
		.y_value      (y_value),
		.last_query   (last_query),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.y_out        (y_out),
		.out_of_range (out_of_range),
		.last_result  (last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Shared state
	// ---------------------------------------------------------------

	// beats waiting to be offered, filled by the stimulus process
	table_beat_t beat_backlog [$];
	// results still owed by the block, oldest first
	lookup_t     awaited_lookups [$];

	// table as the block should hold it, updated as beats are accepted
	logic signed [31:0] table_x [TABLE_DEPTH];
	logic signed [31:0] table_y [TABLE_DEPTH];
	int                 active_points = 2;

	// table as the stimulus has planned it; runs ahead of the accepted one
	int plan_x [TABLE_DEPTH];
	int plan_points = 2;

	int beats_planned = 0;
	int beats_in = 0;
	int loads_in = 0;
	int results_seen = 0;
	int off_table_seen = 0;
	int mismatches = 0;
	int settings_used = 0;
	int stall_left = 0;

	// a stretch in the middle of the run with no random idling on either side
	wire calm = (beats_in >= 400) && (beats_in < 560);

	logic [5:0] opening_counts [7] = '{6'd2, 6'd32, 6'd0, 6'd1, 6'd63, 6'd33, 6'd5};

	// ---------------------------------------------------------------
	// Expected value of one query against the accepted table.
	// Search from slot 0 for the first x not below the query; an exact
	// hit returns that y, running off either end returns the end y with
	// the flag set, else a straight line between the two neighbours.
	// ---------------------------------------------------------------
	function automatic lookup_t interpolate_at(input logic signed [31:0] xq,
			input logic last);
		lookup_t           r;
		int                k;
		longint            dx, dq, dy;
		longint unsigned   mag, part, span, t;
		r.last = last;
		r.off = 1'b0;
		r.y = '0;
		k = 0;
		while (k < active_points && table_x[k] < xq)
			k++;
		if (k == active_points) begin
			r.y = table_y[k - 1];
			r.off = 1'b1;
		end else if (table_x[k] == xq) begin
			r.y = table_y[k];
		end else if (k == 0) begin
			r.y = table_y[0];
			r.off = 1'b1;
		end else begin
			dx = longint'(table_x[k]) - longint'(table_x[k - 1]);
			dq = longint'(xq) - longint'(table_x[k - 1]);
			dy = longint'(table_y[k]) - longint'(table_y[k - 1]);
			// |dy| and dq are both below 2^32, so the product fits 64 bits;
			// dividing the magnitude truncates toward zero
			mag = (dy < 0) ? -dy : dy;
			part = dq;
			span = dx;
			t = (mag * part) / span;
			r.y = (dy < 0) ? table_y[k - 1] - 32'(t) : table_y[k - 1] + 32'(t);
		end
		return r;
	endfunction

	// uniform pick in [lo, hi], span at most 2^32
	function automatic longint pick_in(input longint lo, input longint hi);
		longint span;
		span = hi - lo + 1;
		return lo + (longint'({32'd0, $urandom()}) % span);
	endfunction

	// ---------------------------------------------------------------
	// Input driver: offers backlog beats, holds each until taken, and
	// keeps the predictor in step with what the block has accepted.
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_LOAD;
			point_index <= '0;
			x_value <= '0;
			y_value <= '0;
			last_query <= 1'b0;
		end else begin : drive_in
			table_beat_t nb;
			if (in_valid && in_ready) begin
				beats_in++;
				if (action == ACT_LOAD) begin
					table_x[point_index] = x_value;
					table_y[point_index] = y_value;
					loads_in++;
				end else begin
					awaited_lookups.push_back(interpolate_at(x_value, last_query));
				end
			end
			// a beat on offer stays put until accepted
			if (!in_valid || in_ready) begin
				if (beat_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
					nb = beat_backlog.pop_front();
					in_valid <= 1'b1;
					action <= nb.act;
					point_index <= nb.slot;
					x_value <= nb.x;
					y_value <= nb.y;
					last_query <= nb.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Output monitor: checks each result beat against the oldest owed
	// one and throttles out_ready, with two long hold-offs so the
	// block's single output slot fills and the input side backs up.
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin : take_result
				lookup_t want;
				results_seen++;
				if (out_of_range)
					off_table_seen++;
				if (awaited_lookups.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with none owed, expected nothing, got y_out %h",
						$time, y_out);
				end else begin
					want = awaited_lookups.pop_front();
					if (y_out !== want.y) begin
						mismatches++;
						$display("%0t: y_out expected %h, got %h", $time, want.y, y_out);
					end
					if (out_of_range !== want.off) begin
						mismatches++;
						$display("%0t: out_of_range expected %b, got %b",
							$time, want.off, out_of_range);
					end
					if (last_result !== want.last) begin
						mismatches++;
						$display("%0t: last_result expected %b, got %b",
							$time, want.last, last_result);
					end
				end
				if (results_seen == 120 || results_seen == 450)
					stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 22);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic push_load(input int slot, input int x, input int y, input bit last);
		beat_backlog.push_back('{act: ACT_LOAD, slot: slot[4:0], x: x, y: y, last: last});
		plan_x[slot] = x;
		beats_planned++;
	endtask

	// slot and y are don't-care on a query, so they carry noise
	task automatic push_query(input int x, input bit last);
		beat_backlog.push_back('{act: ACT_QUERY, slot: 5'($urandom_range(0, 31)),
			x: x, y: $urandom(), last: last});
		beats_planned++;
	endtask

	// wait until every beat is taken and every result is back; sampled on
	// the falling edge so the driver's updates have settled
	task automatic settle_block();
		while (beat_backlog.size() != 0 || in_valid || awaited_lookups.size() != 0)
			@(negedge clk);
		// a trailing load has no result to wait for
		repeat (8) @(posedge clk);
	endtask

	// register write; only called with the block idle
	task automatic write_point_count(input logic [5:0] raw);
		int n;
		@(posedge clk);
		cfg_we <= 1'b1;
		num_points <= raw;
		@(posedge clk);
		cfg_we <= 1'b0;
		// 0 and 1 act as 2, anything past the table depth as the depth
		n = (raw < 2) ? 2 : (raw > TABLE_DEPTH) ? TABLE_DEPTH : int'(raw);
		active_points = n;
		plan_points = n;
		settings_used++;
	endtask

	// fill slots 0..n-1: tight, moderate or full-range ascending x,
	// ascending with repeats, or unordered
	task automatic load_table(input int n);
		int     xs [TABLE_DEPTH];
		int     ys [TABLE_DEPTH];
		int     style, k, j;
		longint step_max, x;
		bit     upward;
		style = $urandom_range(0, 4);
		if (style == 0)
			step_max = $urandom_range(1, 16);
		else if (style == 1)
			step_max = $urandom_range(17, 1 << 20);
		else
			step_max = X_SPAN / (n - 1);
		x = X_MIN + pick_in(0, X_SPAN - step_max * (n - 1));
		for (k = 0; k < n; k++) begin
			xs[k] = (style == 4) ? int'($urandom()) : int'(x);
			x += (style == 3 && $urandom_range(0, 3) == 0) ? 0 : pick_in(1, step_max);
			case ($urandom_range(0, 5))
				0: ys[k] = int'(X_MAX);
				1: ys[k] = int'(X_MIN);
				default: ys[k] = $urandom();
			endcase
		end
		upward = $urandom_range(0, 1);
		for (k = 0; k < n; k++) begin
			j = upward ? k : n - 1 - k;
			push_load(j, xs[j], ys[j], $urandom_range(0, 1));
		end
	endtask

	// mostly between neighbours, with hits, both ends and the extremes
	task automatic push_random_query(input bit last);
		int     s;
		longint lo, hi;
		case ($urandom_range(0, 9))
			0: push_query(plan_x[$urandom_range(0, plan_points - 1)], last);
			1: begin
				if (plan_x[0] > X_MIN)
					push_query(int'(pick_in(X_MIN, longint'(plan_x[0]) - 1)), last);
				else
					push_query(plan_x[0], last);
			end
			2: begin
				hi = plan_x[0];
				for (s = 1; s < plan_points; s++)
					if (plan_x[s] > hi)
						hi = plan_x[s];
				if (hi < X_MAX)
					push_query(int'(pick_in(hi + 1, X_MAX)), last);
				else
					push_query(int'(hi), last);
			end
			3: begin
				case ($urandom_range(0, 3))
					0: push_query(int'(X_MIN), last);
					1: push_query(int'(X_MAX), last);
					2: push_query(0, last);
					default: push_query(-1, last);
				endcase
			end
			9: push_query($urandom(), last);
			default: begin
				s = $urandom_range(1, plan_points - 1);
				lo = (plan_x[s - 1] < plan_x[s]) ? plan_x[s - 1] : plan_x[s];
				hi = (plan_x[s - 1] < plan_x[s]) ? plan_x[s] : plan_x[s - 1];
				push_query(int'(pick_in(lo, hi)), last);
			end
		endcase
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int         phase;
		int         slot;
		logic [5:0] raw;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: two points at the reset count, largest possible fall
		// from the top y to the bottom y
		push_load(0, -6553600, 32'h7FFF_FFFF, 1'b0);
		push_load(1, 0, 32'h8000_0000, 1'b0);
		push_query(-3276800, 1'b0);
		push_query(1, 1'b0);
		push_query(-6553600, 1'b1);
		settle_block();

		// four points: below, exact hits on a middle and the last x, between each
		// pair, just past the first x, above, and a load past the points in use
		// carrying last_query
		write_point_count(6'd4);
		push_load(2, 65536, 32768, 1'b0);
		push_load(3, 32'h7FFF_0000, -1, 1'b0);
		push_query(int'(X_MIN), 1'b0);
		push_query(0, 1'b0);
		push_query(-6553599, 1'b0);
		push_query(32768, 1'b1);
		push_query(1000000, 1'b0);
		push_query(32'h7FFF_0000, 1'b0);
		push_query(int'(X_MAX), 1'b0);
		push_load(31, int'(X_MAX), int'(X_MIN), 1'b1);
		push_query(-65536, 1'b1);

		// Random phases: fresh table per setting, then a run of queries
		// with the odd load mixed in; opening settings hit the extremes
		phase = 0;
		while (beats_planned < 930) begin
			settle_block();
			if (phase < 7)
				raw = opening_counts[phase];
			else if ($urandom_range(0, 3) == 0)
				raw = $urandom_range(0, 63);
			else
				raw = $urandom_range(2, 8);
			write_point_count(raw);
			load_table(plan_points);
			repeat ($urandom_range(15, 50)) begin
				if ($urandom_range(0, 19) == 0) begin
					// stray load: either past the table, or a new y on a
					// slot in use with its x kept so the order holds
					if (plan_points < TABLE_DEPTH && $urandom_range(0, 1)) begin
						slot = $urandom_range(plan_points, TABLE_DEPTH - 1);
						push_load(slot, $urandom(), $urandom(), $urandom_range(0, 1));
					end else begin
						slot = $urandom_range(0, plan_points - 1);
						push_load(slot, plan_x[slot], $urandom(), $urandom_range(0, 1));
					end
				end else begin
					push_random_query($urandom_range(0, 7) == 0);
				end
			end
			push_random_query(1'b1);
			phase++;
		end

		settle_block();
		repeat (20) @(posedge clk);
		$display("%0d beats accepted (%0d table loads), %0d results checked, %0d off the table",
			beats_in, loads_in, results_seen, off_table_seen);
		$display("%0d table size settings incl. out-of-range counts; %0d mismatches",
			settings_used, mismatches);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#(10_000_000);
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pli_pkg.sv
hdl/pli_table.sv
hdl/piecewise_linear_interpolator.sv
tb/piecewise_linear_interpolator_tb.sv
